FILE: src/key_press_classifier_unit_macros.svh
// Assertion macros for the key press classifier.
// Each macro takes a label, the clock, the reset and the property terms.
`ifndef KEY_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define KPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key press classifier check failed");

// Next-cycle implication
`define KPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key press classifier check failed");

`else

`define KPC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define KPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/kpc_pkg.sv
package kpc_pkg;

  // Field widths
  localparam int CFG_W    = 10;
  localparam int MASK_W   = 6;
  localparam int KEY_W    = 8;
  localparam int CODE_W   = 8;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 3;
  localparam int HOLD_W   = 10;

  // Opcodes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPEAT = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SHORT_THR  = 3'd0;
  localparam logic [IDX_W-1:0] REG_LONG_THR   = 3'd1;
  localparam logic [IDX_W-1:0] REG_REPEAT_THR = 3'd2;
  localparam logic [IDX_W-1:0] REG_REPEAT_INT = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPEAT_MSK = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0]  RST_SHORT_THR  = 10'd5;
  localparam logic [CFG_W-1:0]  RST_LONG_THR   = 10'd100;
  localparam logic [CFG_W-1:0]  RST_REPEAT_THR = 10'd150;
  localparam logic [CFG_W-1:0]  RST_REPEAT_INT = 10'd20;
  localparam logic [MASK_W-1:0] RST_REPEAT_MSK = 6'd3;

  // Long / repeat code base
  localparam logic [CODE_W-1:0] LONG_BASE = 8'h80;

  typedef struct packed {
    logic [CFG_W-1:0]  short_threshold;
    logic [CFG_W-1:0]  long_threshold;
    logic [CFG_W-1:0]  repeat_threshold;
    logic [CFG_W-1:0]  repeat_interval;
    logic [MASK_W-1:0] repeat_mask;
  } cfg_t;

  // Key state apart from the hold counter, whose width is a parameter
  typedef struct packed {
    logic              scan_active;
    logic [KEY_W-1:0]  held_key;
    logic [CODE_W-1:0] code;
    logic              pressed;
  } key_state_t;

endpackage

FILE: src/kpc_step.sv
// One step of the key qualifier: next state from current state and one beat.
module kpc_step #(
  parameter int COUNT_LIMIT = 1000,
  parameter int KEY_COUNT   = 6
) (
  input  kpc_pkg::cfg_t                                cfg,
  input  kpc_pkg::key_state_t                          state,
  input  logic [$clog2(COUNT_LIMIT+1)-1:0]             counter,
  input  logic [kpc_pkg::OP_W-1:0]                     opcode,
  input  logic [kpc_pkg::KEY_W-1:0]                    key_sample,
  output kpc_pkg::key_state_t                          state_next,
  output logic [$clog2(COUNT_LIMIT+1)-1:0]             counter_next
);

  localparam int CNT_W    = $clog2(COUNT_LIMIT + 1);
  localparam int CMP_W    = (CNT_W > kpc_pkg::CFG_W) ? CNT_W : kpc_pkg::CFG_W;
  localparam int RPT_KEYS = (KEY_COUNT < kpc_pkg::MASK_W) ? KEY_COUNT : kpc_pkg::MASK_W;

  // Position plus one of a key that is one-hot in the low KEY_COUNT bits, else 0
  function automatic logic [kpc_pkg::CODE_W-1:0] key_index(
    input logic [kpc_pkg::KEY_W-1:0] k
  );
    logic [kpc_pkg::CODE_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (k == kpc_pkg::KEY_W'(1 << i)) idx = kpc_pkg::CODE_W'(i + 1);
    end
    return idx;
  endfunction

  logic [kpc_pkg::CODE_W-1:0] idx;
  logic                       rpt_hit;
  logic [CNT_W-1:0]           cnt_inc;
  logic [CMP_W-1:0]           cnt_x;
  logic [CMP_W-1:0]           intv_x;

  assign idx    = key_index(state.held_key);
  assign cnt_x  = CMP_W'(counter);
  assign intv_x = CMP_W'(cfg.repeat_interval);
  assign cnt_inc = (counter < CNT_W'(COUNT_LIMIT)) ? counter + CNT_W'(1) : counter;

  // Held key is enabled for auto-repeat
  always_comb begin
    rpt_hit = 1'b0;
    for (int i = 0; i < RPT_KEYS; i++) begin
      if (cfg.repeat_mask[i] && state.held_key == kpc_pkg::KEY_W'(1 << i)) rpt_hit = 1'b1;
    end
  end

  // Next-state logic
  always_comb begin
    state_next   = state;
    counter_next = counter;
    case (opcode)
      kpc_pkg::OP_SAMPLE: begin
        if (!state.scan_active) begin
          if (key_sample != '0) begin
            state_next.scan_active = 1'b1;
            state_next.pressed     = 1'b1;
            state_next.held_key    = key_sample;
            counter_next           = '0;
          end
        end else if (state.held_key == key_sample) begin
          counter_next = cnt_inc;
          if (CMP_W'(cnt_inc) == CMP_W'(cfg.short_threshold)) state_next.code = idx;
          if (CMP_W'(cnt_inc) == CMP_W'(cfg.long_threshold)) begin
            state_next.code = kpc_pkg::LONG_BASE + idx;
          end
        end else begin
          state_next.scan_active = 1'b0;
          state_next.code        = '0;
          counter_next           = '0;
          if (key_sample == '0) begin
            state_next.held_key = '0;
            state_next.pressed  = 1'b0;
          end
        end
      end
      kpc_pkg::OP_CLEAR: begin
        state_next.code = '0;
      end
      kpc_pkg::OP_REPEAT: begin
        if (rpt_hit && cnt_x >= CMP_W'(cfg.repeat_threshold)) begin
          state_next.code = kpc_pkg::LONG_BASE + idx;
          counter_next    = (cnt_x > intv_x) ? CNT_W'(cnt_x - intv_x) : '0;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

FILE: src/key_press_classifier_unit.sv
// Key press classifier: qualifies raw key samples into short press, long press
// and auto-repeat codes. Every accepted beat gives exactly one result beat. A
// beat passes an input register and then a result register before its result
// is presented; one beat is accepted every cycle while item_stall is low, as
// the step logic forms the next key state and hold counter combinationally.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no beat is in flight, which the block
// itself does not enforce; unknown indexes are ignored.
`include "key_press_classifier_unit_macros.svh"

module key_press_classifier_unit #(
  parameter int COUNT_LIMIT = 1000,
  parameter int KEY_COUNT   = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [kpc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [kpc_pkg::CFG_W-1:0]         cfg_data,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [kpc_pkg::OP_W-1:0]          opcode,
  input  logic [kpc_pkg::KEY_W-1:0]         key_sample,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [kpc_pkg::CODE_W-1:0]        key_code,
  output logic                              pressed,
  output logic [kpc_pkg::HOLD_W-1:0]        hold_count
);

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
  localparam int EXT_W = (CNT_W > kpc_pkg::HOLD_W) ? CNT_W : kpc_pkg::HOLD_W;

  kpc_pkg::cfg_t       cfg;
  kpc_pkg::key_state_t state;
  kpc_pkg::key_state_t state_next;
  logic [CNT_W-1:0]    hold_counter;
  logic [CNT_W-1:0]    hold_counter_next;

  logic                       s1_valid;
  logic [kpc_pkg::OP_W-1:0]   s1_opcode;
  logic [kpc_pkg::KEY_W-1:0]  s1_sample;
  logic                       advance;
  logic [EXT_W-1:0]           cnt_ext;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_threshold  <= kpc_pkg::RST_SHORT_THR;
      cfg.long_threshold   <= kpc_pkg::RST_LONG_THR;
      cfg.repeat_threshold <= kpc_pkg::RST_REPEAT_THR;
      cfg.repeat_interval  <= kpc_pkg::RST_REPEAT_INT;
      cfg.repeat_mask      <= kpc_pkg::RST_REPEAT_MSK;
    end else if (cfg_we) begin
      case (cfg_index)
        kpc_pkg::REG_SHORT_THR:  cfg.short_threshold  <= cfg_data;
        kpc_pkg::REG_LONG_THR:   cfg.long_threshold   <= cfg_data;
        kpc_pkg::REG_REPEAT_THR: cfg.repeat_threshold <= cfg_data;
        kpc_pkg::REG_REPEAT_INT: cfg.repeat_interval  <= cfg_data;
        kpc_pkg::REG_REPEAT_MSK: cfg.repeat_mask      <= cfg_data[kpc_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register frees up when empty or taken this cycle
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_opcode <= opcode;
      s1_sample <= key_sample;
    end
  end

  kpc_step #(
    .COUNT_LIMIT (COUNT_LIMIT),
    .KEY_COUNT   (KEY_COUNT)
  ) u_step (
    .cfg          (cfg),
    .state        (state),
    .counter      (hold_counter),
    .opcode       (s1_opcode),
    .key_sample   (s1_sample),
    .state_next   (state_next),
    .counter_next (hold_counter_next)
  );

  // Key state updates as the beat moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.scan_active <= 1'b0;
      state.held_key    <= '0;
      state.code        <= '0;
      state.pressed     <= 1'b0;
      hold_counter      <= '0;
    end else if (s1_valid && advance) begin
      state        <= state_next;
      hold_counter <= hold_counter_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  assign cnt_ext = EXT_W'(hold_counter_next);

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      key_code   <= state_next.code;
      pressed    <= state_next.pressed;
      hold_count <= cnt_ext[kpc_pkg::HOLD_W-1:0];
    end
  end

  // Checks
  `KPC_ASSERT_IMPLY(a_cnt_limit, clk, rst, 1'b1, hold_counter <= CNT_W'(COUNT_LIMIT))
  `KPC_ASSERT_IMPLY(a_pressed_key, clk, rst, state.pressed, state.held_key != '0)
  `KPC_ASSERT_IMPLY(a_scan_pressed, clk, rst, state.scan_active, state.pressed)
  `KPC_ASSERT_NEXT(a_beat_moves, clk, rst, s1_valid && advance, result_valid)

endmodule
